// ----- hw/rtl/oat_pkg.sv -----
// shared action and status codes for the ordered array table
package oat_pkg;

   // action codes of an input transaction
   localparam logic [2:0] ACT_CLEAR  = 3'd0;
   localparam logic [2:0] ACT_APPEND = 3'd1;
   localparam logic [2:0] ACT_INSERT = 3'd2;
   localparam logic [2:0] ACT_DELETE = 3'd3;
   localparam logic [2:0] ACT_SEARCH = 3'd4;
   localparam logic [2:0] ACT_DUMP   = 3'd5;

   // status codes of a result transaction
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_BADIDX   = 3'd2;
   localparam logic [2:0] STAT_NOTFOUND = 3'd3;
   localparam logic [2:0] STAT_EMPTY    = 3'd4;

   // field widths of the channels
   localparam int unsigned WORD_W = 32;
   localparam int unsigned POS_W  = 6;
   localparam int unsigned FILL_W = 7;

   typedef logic signed [WORD_W-1:0] word_type;

endpackage

// ----- hw/rtl/oat_store.sv -----
// entry storage: one write port, one read port with registered data
module oat_store #(
   parameter int DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  oat_pkg::word_type    wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output oat_pkg::word_type    rd_data
);
   import oat_pkg::*;

   word_type mem_ff [DEPTH];
   word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data registered: it shows in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ordered_array_table.sv -----
// ordered array table: top level with the sequencer around the entry storage
//
// Usage: drive req_action, req_position and req_word and raise start while busy
// is low; the transaction is taken at that clock edge. Results come back on the
// rsp_ ports, each valid for exactly one cycle while rsp_valid is high; the
// receiver cannot stall them, so it must take every strobe.
// Clear, append, an error case, an insert at the end and a delete of the last
// entry finish in the accept cycle: the result shows in the next cycle and busy
// stays low, so one such transaction per cycle is sustained.
// An insert at index p with n entries reads from n - 1 down to p, writing each
// entry one place up (S_UP, S_UP_END), then writes the word at p (S_INS_PUT); a
// delete at p reads from p + 1 to n - 1, writing each one place down (S_DOWN,
// S_DOWN_END). A search reads from index 0 up and ends on the first match or
// after the last entry; a read-all returns one result per cycle. Each entry
// moved or inspected passes once through the single read port of the storage,
// one per cycle, and a shift writes through its single write port. Busy is
// high from the cycle after the accept up to the cycle before the last result.
// Reset empties the table (the count goes to zero) and drops any pending
// result; storage contents are not cleared and are never read before written.
module ordered_array_table #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_action,
   input  logic [oat_pkg::POS_W-1:0]   req_position,
   input  oat_pkg::word_type           req_word,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [oat_pkg::POS_W-1:0]   rsp_found_at,
   output oat_pkg::word_type           rsp_entry,
   output logic [oat_pkg::FILL_W-1:0]  rsp_fill,
   output logic                        rsp_last
);
   import oat_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_UP       = 4'd1;
   localparam logic [3:0] S_UP_END   = 4'd2;
   localparam logic [3:0] S_INS_PUT  = 4'd3;
   localparam logic [3:0] S_DOWN     = 4'd4;
   localparam logic [3:0] S_DOWN_END = 4'd5;
   localparam logic [3:0] S_SCAN     = 4'd6;
   localparam logic [3:0] S_SCAN_END = 4'd7;
   localparam logic [3:0] S_DUMP     = 4'd8;
   localparam logic [3:0] S_DUMP_END = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     pos_ff, pos_in;
   word_type          word_ff, word_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [AW-1:0]     rsp_idx_ff, rsp_idx_in;
   word_type          rsp_entry_ff, rsp_entry_in;
   logic [CW-1:0]     rsp_fill_ff, rsp_fill_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   word_type          wr_data;
   logic [AW-1:0]     rd_addr;
   word_type          rd_data;

   logic              accept;
   logic              full;
   logic [AW-1:0]     last_idx;
   logic [FILL_W-1:0] count_ext;
   logic [FILL_W-1:0] pos_ext;
   logic              match;

   oat_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign full      = (count_ff == CW'(DEPTH));
   assign last_idx  = AW'(count_ff - CW'(1));
   assign count_ext = FILL_W'(count_ff);
   assign pos_ext   = FILL_W'(req_position);
   assign match     = (rd_data == word_ff);
   assign rd_addr   = ptr_ff;

   // sequencer and shared read/compare path
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      rd_ok_in      = 1'b0;
      rd_idx_in     = ptr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_idx_in    = '0;
      rsp_entry_in  = '0;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               word_in = req_word;
               pos_in  = AW'(req_position);
               unique case (req_action) inside
                  ACT_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_APPEND, ACT_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else if (req_action == ACT_INSERT && pos_ext > count_ext) begin
                        rsp_status_in = STAT_BADIDX;
                     end else if (req_action == ACT_APPEND || pos_ext == count_ext) begin
                        // add at the end directly
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_ff);
                        wr_data  = req_word;
                        count_in = count_ff + CW'(1);
                     end else begin
                        rsp_valid_in = 1'b0;
                        ptr_in       = last_idx;
                        state_in     = S_UP;
                     end
                  end
                  ACT_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (pos_ext >= count_ext) begin
                        rsp_status_in = STAT_BADIDX;
                     end else if (AW'(req_position) == last_idx) begin
                        count_in = count_ff - CW'(1);
                     end else begin
                        rsp_valid_in = 1'b0;
                        ptr_in       = AW'(req_position) + AW'(1);
                        state_in     = S_DOWN;
                     end
                  end
                  ACT_SEARCH, ACT_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        ptr_in   = '0;
                        state_in = (req_action == ACT_SEARCH) ? S_SCAN : S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_UP: begin
            // read ptr, write the previous read one place up
            rd_ok_in = 1'b1;
            if (rd_ok_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff + AW'(1);
               wr_data = rd_data;
            end
            if (ptr_ff == pos_ff) begin
               state_in = S_UP_END;
            end else begin
               ptr_in = ptr_ff - AW'(1);
            end
         end
         S_UP_END: begin
            wr_en    = 1'b1;
            wr_addr  = rd_idx_ff + AW'(1);
            wr_data  = rd_data;
            state_in = S_INS_PUT;
         end
         S_INS_PUT: begin
            wr_en        = 1'b1;
            wr_addr      = pos_ff;
            wr_data      = word_ff;
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_DOWN: begin
            // read ptr, write the previous read one place down
            rd_ok_in = 1'b1;
            if (rd_ok_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - AW'(1);
               wr_data = rd_data;
            end
            if (ptr_ff == last_idx) begin
               state_in = S_DOWN_END;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         S_DOWN_END: begin
            wr_en        = 1'b1;
            wr_addr      = rd_idx_ff - AW'(1);
            wr_data      = rd_data;
            count_in     = count_ff - CW'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            if (rd_ok_ff && match) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = rd_idx_ff;
               state_in     = S_IDLE;
            end else begin
               rd_ok_in = 1'b1;
               if (ptr_ff == last_idx) begin
                  state_in = S_SCAN_END;
               end else begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end
         end
         S_SCAN_END: begin
            rsp_valid_in = 1'b1;
            if (match) begin
               rsp_idx_in = rd_idx_ff;
            end else begin
               rsp_status_in = STAT_NOTFOUND;
            end
            state_in = S_IDLE;
         end
         S_DUMP: begin
            rd_ok_in     = 1'b1;
            rsp_valid_in = rd_ok_ff;
            rsp_idx_in   = rd_idx_ff;
            rsp_entry_in = rd_data;
            rsp_last_in  = 1'b0;
            if (ptr_ff == last_idx) begin
               state_in = S_DUMP_END;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         S_DUMP_END: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = rd_idx_ff;
            rsp_entry_in = rd_data;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_fill_in = count_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and result registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found_at = POS_W'(rsp_idx_ff);
   assign rsp_entry    = rsp_entry_ff;
   assign rsp_fill     = FILL_W'(rsp_fill_ff);
   assign rsp_last     = rsp_last_ff;

endmodule

// ----- verif/ordered_array_table_tb.sv -----
// self-checking testbench for the ordered array table: directed table, then random sequences
module ordered_array_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import oat_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 360;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 100;

   // action codes the block ignores
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   // one result transaction as seen on the rsp_ ports
   typedef struct packed {
      logic [2:0]        status;
      logic [POS_W-1:0]  found_at;
      word_type          entry;
      logic [FILL_W-1:0] fill;
      logic              last;
   } table_result_type;

   // one row of directed stimulus; typed rows carry their expected single result
   typedef struct packed {
      logic [2:0]        action;
      logic [POS_W-1:0]  position;
      word_type          word;
      logic              typed;
      logic [2:0]        status;
      logic [POS_W-1:0]  found_at;
      logic [FILL_W-1:0] fill;
   } stim_row_type;

   localparam int NUM_DIRECTED = 23;
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      // action       pos    word             typed status         found  fill
      '{ACT_SEARCH,   6'd0,  32'sd0,          1'b1, STAT_EMPTY,    6'd0,  7'd0},
      '{ACT_DELETE,   6'd0,  32'sd0,          1'b1, STAT_EMPTY,    6'd0,  7'd0},
      '{ACT_DUMP,     6'd0,  32'sd0,          1'b1, STAT_EMPTY,    6'd0,  7'd0},
      '{ACT_INSERT,   6'd1,  32'sd7,          1'b1, STAT_BADIDX,   6'd0,  7'd0},
      '{ACT_APPEND,   6'd63, 32'sh7fffffff,   1'b1, STAT_OK,       6'd0,  7'd1},
      '{ACT_APPEND,   6'd0,  32'sh80000000,   1'b1, STAT_OK,       6'd0,  7'd2},
      '{ACT_INSERT,   6'd0,  -32'sd1,         1'b1, STAT_OK,       6'd0,  7'd3},
      '{ACT_INSERT,   6'd3,  32'sd0,          1'b1, STAT_OK,       6'd0,  7'd4},
      '{ACT_INSERT,   6'd63, 32'sd9,          1'b1, STAT_BADIDX,   6'd0,  7'd4},
      '{ACT_INSERT,   6'd2,  32'sd5,          1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_SEARCH,   6'd0,  32'sd5,          1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_SEARCH,   6'd0,  32'sh80000000,   1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_SEARCH,   6'd0,  -32'sd1,         1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_SEARCH,   6'd0,  32'sd12345,      1'b1, STAT_NOTFOUND, 6'd0,  7'd5},
      '{ACT_DUMP,     6'd0,  32'sd0,          1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_DELETE,   6'd63, 32'sd0,          1'b1, STAT_BADIDX,   6'd0,  7'd5},
      '{ACT_DELETE,   6'd4,  32'sd0,          1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_DELETE,   6'd0,  32'sd0,          1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_SPARE_6,  6'd63, -32'sd1,         1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_SPARE_7,  6'd0,  32'sd0,          1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_DUMP,     6'd0,  32'sd0,          1'b0, STAT_OK,       6'd0,  7'd0},
      '{ACT_CLEAR,    6'd17, 32'sd3,          1'b1, STAT_OK,       6'd0,  7'd0},
      '{ACT_INSERT,   6'd0,  32'sh55aa55aa,   1'b1, STAT_OK,       6'd0,  7'd1}
   };

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [2:0]        req_action;
   logic [POS_W-1:0]  req_position;
   word_type          req_word;
   logic              rsp_valid;
   logic [2:0]        rsp_status;
   logic [POS_W-1:0]  rsp_found_at;
   word_type          rsp_entry;
   logic [FILL_W-1:0] rsp_fill;
   logic              rsp_last;

   // shadow copy of the table and the results still owed by the block
   word_type         shadow_entries [TABLE_DEPTH];
   int               shadow_count;
   table_result_type pending_results [$];

   // side data that travels with the transaction being offered
   logic             row_typed;
   table_result_type row_result;

   int unsigned   n_accepted;
   int unsigned   error_count;
   int unsigned   quiet_cycles;
   bit            idle_enable;

   ordered_array_table #(.DEPTH(TABLE_DEPTH)) uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_position (req_position),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_found_at (rsp_found_at),
      .rsp_entry    (rsp_entry),
      .rsp_fill     (rsp_fill),
      .rsp_last     (rsp_last)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // queue one expected result, fill taken after the action
   function automatic void push_result(logic [2:0] st, logic [POS_W-1:0] at, word_type val,
                                       logic lst);
      table_result_type r;
      r.status   = st;
      r.found_at = at;
      r.entry    = val;
      r.fill     = FILL_W'(shadow_count);
      r.last     = lst;
      pending_results.push_back(r);
   endfunction

   // update the shadow table for one action and queue what it should return
   function automatic void apply_table_action(logic [2:0] act, logic [POS_W-1:0] pos,
                                              word_type w);
      int i;
      int hit;
      int p;
      p = int'(pos);
      case (act)
         ACT_CLEAR: begin
            shadow_count = 0;
            push_result(STAT_OK, '0, '0, 1'b1);
         end
         ACT_APPEND: begin
            if (shadow_count >= TABLE_DEPTH) begin
               push_result(STAT_FULL, '0, '0, 1'b1);
            end else begin
               shadow_entries[shadow_count] = w;
               shadow_count++;
               push_result(STAT_OK, '0, '0, 1'b1);
            end
         end
         ACT_INSERT: begin
            if (shadow_count >= TABLE_DEPTH) begin
               push_result(STAT_FULL, '0, '0, 1'b1);
            end else if (p > shadow_count) begin
               push_result(STAT_BADIDX, '0, '0, 1'b1);
            end else begin
               for (i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p] = w;
               shadow_count++;
               push_result(STAT_OK, '0, '0, 1'b1);
            end
         end
         ACT_DELETE: begin
            if (shadow_count == 0) begin
               push_result(STAT_EMPTY, '0, '0, 1'b1);
            end else if (p >= shadow_count) begin
               push_result(STAT_BADIDX, '0, '0, 1'b1);
            end else begin
               for (i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
               push_result(STAT_OK, '0, '0, 1'b1);
            end
         end
         ACT_SEARCH: begin
            if (shadow_count == 0) begin
               push_result(STAT_EMPTY, '0, '0, 1'b1);
            end else begin
               hit = -1;
               for (i = 0; i < shadow_count; i++)
                  if (hit < 0 && shadow_entries[i] == w) hit = i;
               if (hit >= 0) push_result(STAT_OK, POS_W'(hit), '0, 1'b1);
               else push_result(STAT_NOTFOUND, '0, '0, 1'b1);
            end
         end
         ACT_DUMP: begin
            if (shadow_count == 0) begin
               push_result(STAT_EMPTY, '0, '0, 1'b1);
            end else begin
               for (i = 0; i < shadow_count; i++)
                  push_result(STAT_OK, POS_W'(i), shadow_entries[i], i + 1 == shadow_count);
            end
         end
         default: begin
         end
      endcase
   endfunction

   // compare one field of a result transaction
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // accept transactions into the predictor and check every result strobe
   always @(posedge clock) begin
      int base;
      table_result_type want;
      if (!reset) begin
         quiet_cycles++;
         if (start && !busy) begin
            n_accepted++;
            quiet_cycles = 0;
            base = pending_results.size();
            apply_table_action(req_action, req_position, req_word);
            if (row_typed) begin
               while (pending_results.size() > base) void'(pending_results.pop_back());
               pending_results.push_back(row_result);
            end
         end
         if (rsp_valid === 1'b1) begin
            quiet_cycles = 0;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d entry %0h",
                        $time, rsp_status, rsp_entry);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("found_at", 32'(want.found_at), 32'(rsp_found_at));
               check_field("entry", want.entry, rsp_entry);
               check_field("fill", 32'(want.fill), 32'(rsp_fill));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end else if (rsp_valid !== 1'b0) begin
            $display("%0t: rsp_valid expected 0 or 1, actual %b", $time, rsp_valid);
            error_count++;
         end
         // watchdog on a stalled block
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // offer one transaction, with an occasional gap first, and wait until it is taken
   task automatic send_action(logic [2:0] act, logic [POS_W-1:0] pos, word_type w,
                              logic typed = 1'b0, table_result_type typed_res = '0);
      int unsigned want;
      if (idle_enable && $urandom_range(0, 99) < 16) begin
         start        <= 1'b0;
         req_action   <= 3'($urandom);
         req_position <= POS_W'($urandom);
         req_word     <= word_type'($urandom);
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_action   <= act;
      req_position <= pos;
      req_word     <= w;
      row_typed    <= typed;
      row_result   <= typed_res;
      start        <= 1'b1;
      want = n_accepted + 1;
      do @(negedge clock); while (n_accepted != want);
   endtask

   // mostly values that repeat so searches hit, sometimes any pattern
   function automatic word_type pick_word();
      case ($urandom_range(0, 3))
         0: return word_type'($urandom);
         1: return (shadow_count > 0) ? shadow_entries[$urandom_range(0, shadow_count - 1)]
                                      : word_type'($urandom);
         default: return word_type'($urandom_range(0, 15)) - 32'sd8;
      endcase
   endfunction

   // index near the live range, sometimes any index
   function automatic logic [POS_W-1:0] pick_position();
      if ($urandom_range(0, 4) == 0) return POS_W'($urandom);
      return POS_W'($urandom_range(0, (shadow_count > 63) ? 63 : shadow_count));
   endfunction

   // one random action in the middle of a sequence
   task automatic random_action(inout int unsigned sent);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 22) send_action(ACT_APPEND, POS_W'($urandom), pick_word());
      else if (r < 42) send_action(ACT_INSERT, pick_position(), pick_word());
      else if (r < 60) send_action(ACT_DELETE, pick_position(), word_type'($urandom));
      else if (r < 76) send_action(ACT_SEARCH, POS_W'($urandom), pick_word());
      else if (r < 86) send_action(ACT_DUMP, POS_W'($urandom), word_type'($urandom));
      else if (r < 90) send_action(ACT_CLEAR, POS_W'($urandom), word_type'($urandom));
      else if (r < 95) send_action($urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7,
                                   POS_W'($urandom), word_type'($urandom));
      else send_action(3'($urandom_range(ACT_INSERT, ACT_DELETE)), POS_W'($urandom),
                       word_type'($urandom));
      // ignored actions do not count toward the total
      if (r < 90 || r >= 95) sent++;
   endtask

   // main sequence
   initial begin
      table_result_type typed_res;
      int unsigned sent;
      int unsigned episode;
      int n;
      bit full_run;

      reset        = 1'b1;
      start        = 1'b0;
      req_action   = ACT_CLEAR;
      req_position = '0;
      req_word     = '0;
      row_typed    = 1'b0;
      row_result   = '0;
      n_accepted   = 0;
      error_count  = 0;
      quiet_cycles = 0;
      idle_enable  = 1'b1;
      shadow_count = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows
      foreach (DIRECTED[k]) begin
         typed_res.status   = DIRECTED[k].status;
         typed_res.found_at = DIRECTED[k].found_at;
         typed_res.entry    = '0;
         typed_res.fill     = DIRECTED[k].fill;
         typed_res.last     = 1'b1;
         send_action(DIRECTED[k].action, DIRECTED[k].position, DIRECTED[k].word,
                     DIRECTED[k].typed, typed_res);
      end

      // random sequences: clear, fill, then mixed actions; some run the table full
      sent = 0;
      episode = 0;
      while (sent < RANDOM_ITEMS) begin
         full_run = (episode == 0) || ($urandom_range(0, 7) == 0);
         send_action(ACT_CLEAR, POS_W'($urandom), word_type'($urandom));
         sent++;
         n = full_run ? TABLE_DEPTH : $urandom_range(1, 12);
         repeat (n) begin
            send_action(ACT_APPEND, POS_W'($urandom), pick_word());
            sent++;
            idle_enable = !(sent >= 150 && sent < 250);
         end
         if (full_run) begin
            // full table: both adds refused, then a full readout and shifts near index 0
            send_action(ACT_APPEND, POS_W'($urandom), pick_word());
            send_action(ACT_INSERT, POS_W'($urandom), pick_word());
            send_action(ACT_DUMP, POS_W'($urandom), word_type'($urandom));
            send_action(ACT_DELETE, pick_position(), word_type'($urandom));
            send_action(ACT_INSERT, POS_W'(shadow_count), pick_word());
            send_action(ACT_DELETE, POS_W'($urandom_range(0, 3)), word_type'($urandom));
            send_action(ACT_INSERT, POS_W'($urandom_range(0, 3)), pick_word());
            sent += 7;
         end
         repeat ($urandom_range(8, 24)) begin
            random_action(sent);
            idle_enable = !(sent >= 150 && sent < 250);
         end
         episode++;
      end
      start <= 1'b0;

      // drain and report
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
